/* rtl/sitda_pkg.sv */
`default_nettype none

package sitda_pkg;

	// integer width taken from the low bits of the input word
	localparam int INT_WIDTH = 32;
	localparam int VALUE_W   = 32;
	localparam int CHAR_W    = 6;

	// decimal digits needed for the largest magnitude, ceil(INT_WIDTH * log10(2))
	localparam int NUM_DIGITS = (INT_WIDTH * 30103 + 99999) / 100000;
	localparam int IDX_W      = $clog2(NUM_DIGITS);

	// divide by ten as multiply by reciprocal, exact for every 32-bit magnitude
	localparam int                 RECIP_W = 32;
	localparam logic [RECIP_W-1:0] RECIP   = 32'hCCCC_CCCD;
	localparam int                 RSHIFT  = 35;
	localparam int                 PROD_W  = INT_WIDTH + RECIP_W;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
	localparam logic [3:0]        DIGIT_BASE  = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIVIDE,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic divide;
		logic push_sign;
		logic push_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic q_zero;
		logic neg;
		logic idx_zero;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/sitda_in_if.sv */
`default_nettype none

interface sitda_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sitda_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

/* rtl/sitda_out_if.sv */
`default_nettype none

interface sitda_out_if;
	logic                          valid;
	logic                          ready;
	logic [sitda_pkg::CHAR_W-1:0]  ascii_char;
	logic                          is_last;

	modport source (output valid, output ascii_char, output is_last, input ready);
	modport sink (input valid, input ascii_char, input is_last, output ready);
endinterface

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
`default_nettype none

// signed 32-bit integer to decimal ascii text. each word taken on num is turned into its
// decimal characters on text, most significant first: a leading '-' for negative values, no
// leading zeros, a single '0' for zero, and is_last set on the final character. the most
// negative value converts exactly. one number is handled at a time: the magnitude is
// registered as the input word is taken, the prep state starts the reciprocal multiply, then a
// divide-by-ten unit yields one digit per cycle until the quotient is zero, and the characters
// go out one per cycle while text is ready. a result has at most eleven characters with a
// minus sign. a new word can be accepted once the last character sits in the output register,
// even if it is not yet taken.
module signed_int_to_decimal_ascii (
	input wire logic   clk,
	input wire logic   arst_n,
	sitda_in_if.sink   num,
	sitda_out_if.source text
);

	// command and status between sequencer and datapath
	sitda_pkg::dp_cmd_t    cmd;
	sitda_pkg::dp_status_t status;

	// sequencer: idle, multiply prep, divide loop, sign, digit emission
	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num.valid),
		.num_ready (num.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath: magnitude, divide by ten, digit buffer, output register
	sitda_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.value      (num.value),
		.text_valid (text.valid),
		.text_ready (text.ready),
		.ascii_char (text.ascii_char),
		.is_last    (text.is_last)
	);

endmodule

`default_nettype wire

/* rtl/sitda_dp.sv */
`default_nettype none

module sitda_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sitda_pkg::dp_cmd_t                    cmd,
	output      sitda_pkg::dp_status_t                 status,
	input  wire logic signed [sitda_pkg::VALUE_W-1:0]  value,
	output      logic                                  text_valid,
	input  wire logic                                  text_ready,
	output      logic [sitda_pkg::CHAR_W-1:0]          ascii_char,
	output      logic                                  is_last
);

	localparam int W = sitda_pkg::INT_WIDTH;

	logic [W-1:0]                      v_in;
	logic [W-1:0]                      mag_in;
	logic                              neg_q;
	logic [W-1:0]                      mag_q;
	logic [sitda_pkg::PROD_W-1:0]      prod_q;
	logic [W-1:0]                      quot;
	logic [3:0]                        rem;
	logic [3:0]                        digit_q [sitda_pkg::NUM_DIGITS];
	logic [sitda_pkg::IDX_W-1:0]       idx_q;
	logic                              valid_q;
	logic [sitda_pkg::CHAR_W-1:0]      char_q;
	logic                              last_q;

	assign v_in   = W'(value);
	assign mag_in = v_in[W-1] ? (~v_in + W'(1)) : v_in;

	// quotient and remainder of the current magnitude by ten
	assign quot = W'(prod_q >> sitda_pkg::RSHIFT);
	assign rem  = 4'(mag_q[3:0] - 4'(quot[3:0] * sitda_pkg::DIGIT_BASE));

	assign status.q_zero   = (quot == '0);
	assign status.neg      = neg_q;
	assign status.idx_zero = (idx_q == '0);
	assign status.out_free = !valid_q || text_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= v_in[W-1];
			mag_q <= mag_in;
		end else if (cmd.prep) begin
			prod_q <= sitda_pkg::PROD_W'(mag_q) * sitda_pkg::RECIP;
		end else if (cmd.divide) begin
			mag_q          <= quot;
			prod_q         <= sitda_pkg::PROD_W'(quot) * sitda_pkg::RECIP;
			digit_q[idx_q] <= rem;
		end
	end

	// digit index: counts up while dividing, stops on the leading digit, then counts down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.divide && !status.q_zero) begin
			idx_q <= idx_q + sitda_pkg::IDX_W'(1);
		end else if (cmd.push_digit && !status.idx_zero) begin
			idx_q <= idx_q - sitda_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push_sign || cmd.push_digit) begin
			valid_q <= 1'b1;
		end else if (text_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_sign) begin
			char_q <= sitda_pkg::ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.push_digit) begin
			char_q <= sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(digit_q[idx_q]);
			last_q <= status.idx_zero;
		end
	end

	assign text_valid = valid_q;
	assign ascii_char = char_q;
	assign is_last    = last_q;

endmodule

`default_nettype wire

/* rtl/sitda_ctrl.sv */
`default_nettype none

module sitda_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   num_valid,
	output      logic                   num_ready,
	output      sitda_pkg::dp_cmd_t     cmd,
	input  wire sitda_pkg::dp_status_t  status
);

	sitda_pkg::state_t state_q;
	sitda_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		num_ready = 1'b0;
		unique case (state_q)
			sitda_pkg::ST_IDLE: begin
				num_ready = 1'b1;
				if (num_valid) begin
					cmd.load = 1'b1;
					state_d  = sitda_pkg::ST_PREP;
				end
			end
			sitda_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sitda_pkg::ST_DIVIDE;
			end
			sitda_pkg::ST_DIVIDE: begin
				cmd.divide = 1'b1;
				if (status.q_zero) begin
					state_d = status.neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGITS;
				end
			end
			sitda_pkg::ST_SIGN: begin
				if (status.out_free) begin
					cmd.push_sign = 1'b1;
					state_d       = sitda_pkg::ST_DIGITS;
				end
			end
			sitda_pkg::ST_DIGITS: begin
				if (status.out_free) begin
					cmd.push_digit = 1'b1;
					if (status.idx_zero) begin
						state_d = sitda_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
